// ----- src/assert_macros.svh -----
// Assertion macros used by the battery level monitor RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// The antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

// The expression never holds.
`define ASSERT_NEVER(label, clk, rst, a) \
  label: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("forbidden condition seen");

`endif

// ----- src/blm_pkg.sv -----
// Package for the battery level monitor: widths, discharge curve table,
// register indexes and the alert status struct. No dependencies.
`default_nettype none

package blm_pkg;

  localparam int MV_W        = 16;
  localparam int PCT_W       = 7;
  localparam int CURVE_MV_W  = 12;
  localparam int CURVE_POINTS = 11;
  localparam int SEG_W       = $clog2(CURVE_POINTS);
  localparam int OFF_W       = 7;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 7;

  // Breakpoints from full charge downwards, with their percentages.
  localparam logic [CURVE_MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
    12'd3600, 12'd3550, 12'd3500, 12'd3450, 12'd3400, 12'd3350,
    12'd3300, 12'd3250, 12'd3200, 12'd3100, 12'd3000
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd40, 7'd30, 7'd20, 7'd10, 7'd0
  };

  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

  // Every segment spans ten percent, over either 50 mV or 100 mV. The
  // quotient off * 10 / span is then off / 5 or off / 10, taken as
  // off * 205 shifted right by 10 or 11 bits; exact for off below 100.
  localparam logic [CURVE_MV_W-1:0] SPAN_WIDE  = 12'd100;
  localparam logic [7:0]            RECIP_MUL  = 8'd205;
  localparam int                    SHIFT_NARROW = 10;
  localparam int                    SHIFT_WIDE   = 11;
  localparam int                    PROD_W     = OFF_W + 8;

  localparam logic [PCT_W-1:0] LOW_THRESHOLD_RESET      = 7'd15;
  localparam logic [PCT_W-1:0] CRITICAL_THRESHOLD_RESET = 7'd5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOW_THRESHOLD      = 8'd0,
    REG_CRITICAL_THRESHOLD = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic low;
    logic critical;
  } alert_t;

endpackage

`default_nettype wire

// ----- src/blm_if.sv -----
// Valid/ready channel interfaces for the battery level monitor.
// Depends on blm_pkg for the field widths.
`default_nettype none

interface blm_sample_if;
  logic                       valid;
  logic                       ready;
  logic [blm_pkg::MV_W-1:0]   millivolts;

  modport source (output valid, output millivolts, input ready);
  modport sink   (input valid, input millivolts, output ready);
endinterface

interface blm_result_if;
  logic                       valid;
  logic                       ready;
  logic [blm_pkg::PCT_W-1:0]  percent;
  logic                       low_alert;
  logic                       critical_alert;

  modport source (output valid, output percent, output low_alert, output critical_alert,
                  input ready);
  modport sink   (input valid, input percent, input low_alert, input critical_alert,
                  output ready);
endinterface

`default_nettype wire

// ----- src/battery_level_monitor.sv -----
// Battery level monitor top level: input stage, charge lookup, alert latches
// and result register. Depends on blm_pkg, blm_if, blm_curve and blm_alert.
//
// Usage. Voltage samples arrive as beats on the sample channel (millivolts,
// unsigned) and each produces exactly one beat on the result channel
// carrying the state of charge in whole percent plus the low and critical
// alert flags. A beat moves when valid and ready are both high.
//
// A sample is taken into the input register, converted by the curve lookup
// and alert logic, and then held in the result register. Throughput is one
// sample per cycle, set by the two register stages which advance together
// whenever the result register is empty or being drained.
//
// When the receiver stalls, the result register holds its beat and the
// input register fills; sample ready then drops until the result moves.
// The alert latches update only as a sample moves into the result
// register, so each alert fires on at most one result beat.
//
// The user must write thresholds via the cfg port only while the block is
// idle; the block does not enforce this. A synchronous reset (rst) empties
// both stages, clears alert latches, restores thresholds to 15 and 5 percent.
`default_nettype none

module battery_level_monitor (
  input  wire logic                             clk,
  input  wire logic                             rst,
  blm_sample_if.sink                            sample,
  blm_result_if.source                          result,
  input  wire logic                             cfg_wr_en,
  input  wire logic [blm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [blm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [blm_pkg::PCT_W-1:0] low_threshold;
  logic [blm_pkg::PCT_W-1:0] critical_threshold;

  logic                      s1_valid;
  logic [blm_pkg::MV_W-1:0]  s1_mv;
  logic                      s1_move;

  logic                      out_valid;
  logic [blm_pkg::PCT_W-1:0] out_percent;
  logic                      out_low;
  logic                      out_crit;

  logic [blm_pkg::PCT_W-1:0] pct;
  blm_pkg::alert_t           fire;

  // Threshold registers; writes to unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold      <= blm_pkg::LOW_THRESHOLD_RESET;
      critical_threshold <= blm_pkg::CRITICAL_THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      case (blm_pkg::cfg_reg_t'(cfg_index))
        blm_pkg::REG_LOW_THRESHOLD:      low_threshold      <= cfg_data;
        blm_pkg::REG_CRITICAL_THRESHOLD: critical_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // The first stage drains into the result register whenever that one is
  // empty or its beat is being taken this cycle.
  assign s1_move      = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_mv <= sample.millivolts;
    end
  end

  blm_curve u_curve (
    .millivolts (s1_mv),
    .percent    (pct)
  );

  blm_alert u_alert (
    .clk                (clk),
    .rst                (rst),
    .advance            (s1_move),
    .percent            (pct),
    .low_threshold      (low_threshold),
    .critical_threshold (critical_threshold),
    .fire               (fire)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_percent <= pct;
      out_low     <= fire.low;
      out_crit    <= fire.critical;
    end
  end

  assign result.valid          = out_valid;
  assign result.percent        = out_percent;
  assign result.low_alert      = out_low;
  assign result.critical_alert = out_crit;

endmodule

`default_nettype wire

// ----- src/blm_curve.sv -----
// Piecewise linear charge lookup: millivolts to whole percent.
// Depends on blm_pkg for the curve table and widths.
`default_nettype none

module blm_curve (
  input  wire logic [blm_pkg::MV_W-1:0]  millivolts,
  output logic      [blm_pkg::PCT_W-1:0] percent
);

  logic                               found;
  logic [blm_pkg::SEG_W-1:0]          seg;
  logic [blm_pkg::SEG_W-1:0]          seg_above;
  logic [blm_pkg::CURVE_MV_W-1:0]     span;
  logic [blm_pkg::MV_W-1:0]           diff;
  logic [blm_pkg::OFF_W-1:0]          off;
  logic [blm_pkg::PROD_W-1:0]         prod;
  logic [blm_pkg::PCT_W-1:0]          step;

  // Independent compares against each lower breakpoint; the highest voltage match wins.
  always_comb begin
    found = 1'b0;
    seg   = '0;
    for (int k = blm_pkg::CURVE_POINTS - 1; k >= 1; k--) begin
      if (millivolts >= {{(blm_pkg::MV_W-blm_pkg::CURVE_MV_W){1'b0}}, blm_pkg::CURVE_MV[k]})
      begin
        found = 1'b1;
        seg   = blm_pkg::SEG_W'(k);
      end
    end
  end

  assign seg_above = seg - blm_pkg::SEG_W'(1);
  assign span = blm_pkg::CURVE_MV[seg_above] - blm_pkg::CURVE_MV[seg];
  assign diff = millivolts - {{(blm_pkg::MV_W-blm_pkg::CURVE_MV_W){1'b0}},
                              blm_pkg::CURVE_MV[seg]};
  assign off  = diff[blm_pkg::OFF_W-1:0];
  assign prod = {{(blm_pkg::PROD_W-blm_pkg::OFF_W){1'b0}}, off} *
                {{(blm_pkg::PROD_W-8){1'b0}}, blm_pkg::RECIP_MUL};

  always_comb begin
    if (span == blm_pkg::SPAN_WIDE) begin
      step = blm_pkg::PCT_W'(prod >> blm_pkg::SHIFT_WIDE);
    end else begin
      step = blm_pkg::PCT_W'(prod >> blm_pkg::SHIFT_NARROW);
    end
  end

  always_comb begin
    if (millivolts >= {{(blm_pkg::MV_W-blm_pkg::CURVE_MV_W){1'b0}}, blm_pkg::CURVE_MV[0]})
    begin
      percent = blm_pkg::PCT_FULL;
    end else if (found) begin
      percent = blm_pkg::CURVE_PCT[seg] + step;
    end else begin
      percent = blm_pkg::PCT_EMPTY;
    end
  end

endmodule

`default_nettype wire

// ----- src/blm_alert.sv -----
// Once-only low and critical alert latches for the battery level monitor.
// Depends on blm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module blm_alert (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       advance,
  input  wire logic [blm_pkg::PCT_W-1:0]  percent,
  input  wire logic [blm_pkg::PCT_W-1:0]  low_threshold,
  input  wire logic [blm_pkg::PCT_W-1:0]  critical_threshold,
  output blm_pkg::alert_t                 fire
);

  logic low_alert_done;
  logic critical_alert_done;

  // Critical takes priority; when it fires the low check is skipped.
  always_comb begin
    fire.critical = (percent <= critical_threshold) && !critical_alert_done;
    fire.low      = !fire.critical && (percent <= low_threshold) && !low_alert_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_alert_done      <= 1'b0;
      critical_alert_done <= 1'b0;
    end else if (advance) begin
      if (fire.critical) begin
        critical_alert_done <= 1'b1;
      end
      if (fire.low) begin
        low_alert_done <= 1'b1;
      end
    end
  end

  `ASSERT_NEXT(a_crit_latches, clk, rst, advance && fire.critical, critical_alert_done)
  `ASSERT_NEXT(a_low_sticky, clk, rst, low_alert_done, low_alert_done)
  `ASSERT_IMPLIES(a_no_refire, clk, rst, critical_alert_done, !fire.critical)

endmodule

`default_nettype wire
